>>> sv/ket_pkg.sv
// ----------------------------------------------------------------------------
// Keyed entry table package
// Sizes, operation and status codes, controller states and the control
// bundle that the controller broadcasts along the row of table cells.
// ----------------------------------------------------------------------------
package ket_pkg;

   // Built table depth, the index width that follows from it, and the fixed widths.
   localparam int DEPTH   = 64;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = 7;
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 64;

   // Operation codes carried by an input transaction.
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_UPDATE = 2'd2,
      OP_GET    = 2'd3
   } op_type;

   // Status codes returned with every result.
   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_FULL       = 3'd1,
      STATUS_DUP_ADD    = 3'd2,
      STATUS_DEL_MISS   = 3'd3,
      STATUS_GET_MISS   = 3'd4,
      STATUS_UPD_CLASH  = 3'd5,
      STATUS_UPD_MISS   = 3'd6
   } status_type;

   // Controller states.
   typedef enum logic {
      STATE_IDLE  = 1'b0,
      STATE_APPLY = 1'b1
   } state_type;

   // Control broadcast from the controller to every cell.
   typedef struct packed {
      logic                      compare;
      logic signed [KEY_W-1:0]   cmp_key;
      logic signed [KEY_W-1:0]   cmp_new_key;
      logic [CNT_W-1:0]          count;
      logic                      do_add;
      logic                      do_delete;
      logic                      do_update;
      logic signed [KEY_W-1:0]   wr_key;
      logic [VALUE_W-1:0]        wr_value;
   } cell_ctrl_type;

endpackage

>>> sv/ket_if.sv
// ----------------------------------------------------------------------------
// Keyed entry table channels
// Valid/ready channels for requests, responses and the capacity register.
// ----------------------------------------------------------------------------

// Request channel: one table operation per transaction.
interface ket_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         op;
   logic signed [ket_pkg::KEY_W-1:0]   key;
   logic signed [ket_pkg::KEY_W-1:0]   new_key;
   logic [ket_pkg::VALUE_W-1:0]        entry_value;

   modport source (output valid, op, key, new_key, entry_value, input ready);
   modport sink (input valid, op, key, new_key, entry_value, output ready);
endinterface

// Response channel: one result per request.
interface ket_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [2:0]                         status;
   logic signed [ket_pkg::KEY_W-1:0]   found_key;
   logic [ket_pkg::VALUE_W-1:0]        found_value;
   logic [ket_pkg::CNT_W-1:0]          entry_count;

   modport source (output valid, status, found_key, found_value, entry_count,
                   input ready);
   modport sink (input valid, status, found_key, found_value, entry_count,
                 output ready);
endinterface

// Capacity register write channel.
interface ket_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ket_pkg::CNT_W-1:0]          capacity;

   modport source (output valid, capacity, input ready);
   modport sink (input valid, capacity, output ready);
endinterface

>>> sv/ket_cell.sv
// ----------------------------------------------------------------------------
// Keyed entry table cell
// Holds one entry, compares it against the request keys, is written on add or
// update, and shifts down from above when it or an entry below is deleted.
// ----------------------------------------------------------------------------
module ket_cell (
   input  logic                                clock,
   input  logic [ket_pkg::IDX_W-1:0]           cell_index,
   input  ket_pkg::cell_ctrl_type              ctrl,
   input  logic signed [ket_pkg::KEY_W-1:0]    next_key,
   input  logic [ket_pkg::VALUE_W-1:0]         next_value,
   input  logic                                shift_in,
   output logic                                shift_out,
   output logic signed [ket_pkg::KEY_W-1:0]    key_out,
   output logic [ket_pkg::VALUE_W-1:0]         value_out,
   output logic                                hit_key,
   output logic                                hit_new_key,
   output logic signed [ket_pkg::KEY_W-1:0]    found_key,
   output logic [ket_pkg::VALUE_W-1:0]         found_value
);

   logic signed [ket_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [ket_pkg::VALUE_W-1:0]        value_ff, value_in;
   logic                               hit_key_ff, hit_key_in;
   logic                               hit_new_ff, hit_new_in;
   logic                               active;
   logic                               at_tail;

   // The cell holds a live entry when its place lies below the count.
   assign active  = ({1'b0, cell_index} < (ket_pkg::IDX_W + 1)'(ctrl.count));
   assign at_tail = ({1'b0, cell_index} == (ket_pkg::IDX_W + 1)'(ctrl.count));

   // Key comparison is captured when a transaction is accepted.
   always_comb begin
      hit_key_in = hit_key_ff;
      hit_new_in = hit_new_ff;
      if (ctrl.compare) begin
         hit_key_in = active && (key_ff == ctrl.cmp_key);
         hit_new_in = active && (key_ff == ctrl.cmp_new_key);
      end
   end

   // Entry update: append at the tail, replace on update, shift on delete.
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctrl.do_add && at_tail) begin
         key_in   = ctrl.wr_key;
         value_in = ctrl.wr_value;
      end else if (ctrl.do_update && hit_key_ff) begin
         key_in   = ctrl.wr_key;
         value_in = ctrl.wr_value;
      end else if (ctrl.do_delete && shift_out) begin
         key_in   = next_key;
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      value_ff   <= value_in;
      hit_key_ff <= hit_key_in;
      hit_new_ff <= hit_new_in;
   end

   // Every entry above the deleted one moves down one place.
   assign shift_out   = shift_in | hit_key_ff;
   assign key_out     = key_ff;
   assign value_out   = value_ff;
   assign hit_key     = hit_key_ff;
   assign hit_new_key = hit_new_ff;
   assign found_key   = hit_key_ff ? key_ff : '0;
   assign found_value = hit_key_ff ? value_ff : '0;

endmodule

>>> sv/keyed_entry_table.sv
// ----------------------------------------------------------------------------
// Keyed entry table
// Compacting key/value table built as a row of cells, one entry per cell.
// ----------------------------------------------------------------------------
// Result: the result register loads in the cycle after a request is accepted.
// A new request waits until the last is applied; all cells compare in the accept
// cycle and apply the add, update or delete shift in the following cycle.
// Reset: synchronous, active high; the table empties and capacity returns
// to the built depth. Entry storage itself is not cleared.
// ----------------------------------------------------------------------------
module keyed_entry_table (
   input  logic      clock,
   input  logic      reset,
   ket_req_if.sink   req_port,
   ket_rsp_if.source rsp_port,
   ket_csr_if.sink   csr_port
);

   localparam int D = ket_pkg::DEPTH;

   ket_pkg::state_type                 state_ff, state_in;
   logic [ket_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [ket_pkg::CNT_W-1:0]          capacity_ff, capacity_in;
   ket_pkg::op_type                    op_ff, op_in;
   logic signed [ket_pkg::KEY_W-1:0]   key_ff, key_in;
   logic signed [ket_pkg::KEY_W-1:0]   new_key_ff, new_key_in;
   logic [ket_pkg::VALUE_W-1:0]        value_ff, value_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   ket_pkg::status_type                status_ff, status_in;
   logic signed [ket_pkg::KEY_W-1:0]   rsp_key_ff, rsp_key_in;
   logic [ket_pkg::VALUE_W-1:0]        rsp_value_ff, rsp_value_in;
   logic [ket_pkg::CNT_W-1:0]          rsp_count_ff, rsp_count_in;

   logic                               req_accept;
   logic                               applying;
   ket_pkg::cell_ctrl_type             ctrl;

   logic signed [ket_pkg::KEY_W-1:0]   key_chain [D+1];
   logic [ket_pkg::VALUE_W-1:0]        value_chain [D+1];
   logic [D:0]                         shift_chain;
   logic [D-1:0]                       hit_key_vec;
   logic [D-1:0]                       hit_new_vec;
   logic signed [ket_pkg::KEY_W-1:0]   cell_found_key [D];
   logic [ket_pkg::VALUE_W-1:0]        cell_found_value [D];

   logic                               any_hit;
   logic                               any_new_hit;
   logic signed [ket_pkg::KEY_W-1:0]   sel_key;
   logic [ket_pkg::VALUE_W-1:0]        sel_value;
   logic                               is_full;
   logic                               add_ok, del_ok, upd_ok;

   // Next state.
   always_comb begin
      case (state_ff)
         ket_pkg::STATE_IDLE:  state_in = req_accept ? ket_pkg::STATE_APPLY
                                                     : ket_pkg::STATE_IDLE;
         ket_pkg::STATE_APPLY: state_in = ket_pkg::STATE_IDLE;
         default:              state_in = ket_pkg::STATE_IDLE;
      endcase
   end

   // Controller outputs: in the idle state, requests are taken out of reset once
   // the response slot is free.
   always_comb begin
      case (state_ff)
         ket_pkg::STATE_IDLE: begin
            req_port.ready = !reset && (!rsp_valid_ff || rsp_port.ready);
            applying       = 1'b0;
         end
         ket_pkg::STATE_APPLY: begin
            req_port.ready = 1'b0;
            applying       = 1'b1;
         end
         default: begin
            req_port.ready = 1'b0;
            applying       = 1'b0;
         end
      endcase
   end

   assign req_accept = req_port.valid && req_port.ready;

   // Request capture.
   always_comb begin
      op_in      = op_ff;
      key_in     = key_ff;
      new_key_in = new_key_ff;
      value_in   = value_ff;
      if (req_accept) begin
         op_in      = ket_pkg::op_type'(req_port.op);
         key_in     = req_port.key;
         new_key_in = req_port.new_key;
         value_in   = req_port.entry_value;
      end
   end

   // Capacity register; writes above the built depth saturate.
   assign csr_port.ready = !reset;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_port.valid) begin
         capacity_in = (csr_port.capacity > ket_pkg::CNT_W'(D))
                       ? ket_pkg::CNT_W'(D) : csr_port.capacity;
      end
   end

   // Reduce the registered cell flags and select the matching entry.
   always_comb begin
      sel_key   = '0;
      sel_value = '0;
      for (int i = 0; i < D; i++) begin
         sel_key   = sel_key | cell_found_key[i];
         sel_value = sel_value | cell_found_value[i];
      end
   end

   assign any_hit     = |hit_key_vec;
   assign any_new_hit = |hit_new_vec;
   assign is_full     = (({1'b0, count_ff} + 8'd1) > {1'b0, capacity_ff})
                        || (count_ff >= ket_pkg::CNT_W'(D));

   // Decide the outcome of the operation being applied.
   always_comb begin
      add_ok       = 1'b0;
      del_ok       = 1'b0;
      upd_ok       = 1'b0;
      status_in    = ket_pkg::STATUS_OK;
      rsp_key_in   = '0;
      rsp_value_in = '0;
      case (op_ff)
         ket_pkg::OP_ADD: begin
            if (is_full) begin
               status_in = ket_pkg::STATUS_FULL;
            end else if (any_hit) begin
               status_in = ket_pkg::STATUS_DUP_ADD;
            end else begin
               add_ok = 1'b1;
            end
         end
         ket_pkg::OP_DELETE: begin
            if (!any_hit) begin
               status_in = ket_pkg::STATUS_DEL_MISS;
            end else begin
               del_ok = 1'b1;
            end
         end
         ket_pkg::OP_UPDATE: begin
            if ((new_key_ff != key_ff) && any_new_hit) begin
               status_in = ket_pkg::STATUS_UPD_CLASH;
            end else if (!any_hit) begin
               status_in = ket_pkg::STATUS_UPD_MISS;
            end else begin
               upd_ok = 1'b1;
            end
         end
         ket_pkg::OP_GET: begin
            if (!any_hit) begin
               status_in = ket_pkg::STATUS_GET_MISS;
            end else begin
               rsp_key_in   = sel_key;
               rsp_value_in = sel_value;
            end
         end
         default: begin
            status_in = ket_pkg::STATUS_OK;
         end
      endcase
   end

   // Entry count follows successful adds and deletes.
   always_comb begin
      count_in = count_ff;
      if (applying && add_ok) begin
         count_in = count_ff + ket_pkg::CNT_W'(1);
      end else if (applying && del_ok) begin
         count_in = count_ff - ket_pkg::CNT_W'(1);
      end
   end

   // Response register: loaded when an operation is applied, freed on a
   // response transaction.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (applying) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ket_pkg::STATE_IDLE;
         count_ff     <= '0;
         capacity_ff  <= ket_pkg::CNT_W'(D);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      new_key_ff <= new_key_in;
      value_ff   <= value_in;
      if (applying) begin
         status_ff    <= status_in;
         rsp_key_ff   <= rsp_key_in;
         rsp_value_ff <= rsp_value_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.status      = status_ff;
   assign rsp_port.found_key   = rsp_key_ff;
   assign rsp_port.found_value = rsp_value_ff;
   assign rsp_port.entry_count = rsp_count_ff;

   // Control broadcast to the cells.
   always_comb begin
      ctrl.compare     = req_accept;
      ctrl.cmp_key     = req_port.key;
      ctrl.cmp_new_key = req_port.new_key;
      ctrl.count       = count_ff;
      ctrl.do_add      = applying && add_ok;
      ctrl.do_delete   = applying && del_ok;
      ctrl.do_update   = applying && upd_ok;
      ctrl.wr_key      = (op_ff == ket_pkg::OP_UPDATE) ? new_key_ff : key_ff;
      ctrl.wr_value    = value_ff;
   end

   // Row of cells; on delete, each cell above the deleted one hands its entry down.
   assign shift_chain[0]  = 1'b0;
   assign key_chain[D]    = '0;
   assign value_chain[D]  = '0;

   for (genvar g = 0; g < D; g++) begin : g_cell
      ket_cell u_cell (
         .clock       (clock),
         .cell_index  (ket_pkg::IDX_W'(g)),
         .ctrl        (ctrl),
         .next_key    (key_chain[g+1]),
         .next_value  (value_chain[g+1]),
         .shift_in    (shift_chain[g]),
         .shift_out   (shift_chain[g+1]),
         .key_out     (key_chain[g]),
         .value_out   (value_chain[g]),
         .hit_key     (hit_key_vec[g]),
         .hit_new_key (hit_new_vec[g]),
         .found_key   (cell_found_key[g]),
         .found_value (cell_found_value[g])
      );
   end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Keyed entry table testbench
// Drives add, delete, update and get transactions into the table and checks
// every response against a behavioural copy of the table held in a small
// scoreboard. A short directed sequence covers the corner cases. Random
// phases at several capacities follow, with idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS_PER_RUN = 1500;

   // One expected response.
   typedef struct {
      ket_pkg::status_type                     status;
      logic signed [ket_pkg::KEY_W-1:0]        found_key;
      logic [ket_pkg::VALUE_W-1:0]             found_value;
      logic [ket_pkg::CNT_W-1:0]               entry_count;
   } table_response_type;

   // Table predictor and response checker.
   class table_scoreboard_type;
      logic signed [ket_pkg::KEY_W-1:0] entry_keys [ket_pkg::DEPTH];
      logic [ket_pkg::VALUE_W-1:0]      entry_values [ket_pkg::DEPTH];
      int unsigned                      entries;
      int unsigned                      capacity_limit;
      table_response_type               expected_responses [$];
      int unsigned                      errors;

      function new();
         entries        = 0;
         capacity_limit = ket_pkg::DEPTH;
         errors         = 0;
      endfunction

      task report_mismatch(input string msg);
         errors++;
         $display("%0t ns: mismatch: %s", $realtime, msg);
      endtask

      // A capacity above the built depth saturates to the depth.
      function void set_capacity(input logic [ket_pkg::CNT_W-1:0] value);
         capacity_limit = (value > ket_pkg::DEPTH) ? ket_pkg::DEPTH : value;
      endfunction

      function int find_entry(input logic signed [ket_pkg::KEY_W-1:0] k);
         for (int i = 0; i < entries; i++) begin
            if (entry_keys[i] == k) return i;
         end
         return -1;
      endfunction

      // Applies one accepted request to the table and queues its response.
      function void record_request(input ket_pkg::op_type op,
                                   input logic signed [ket_pkg::KEY_W-1:0] k,
                                   input logic signed [ket_pkg::KEY_W-1:0] nk,
                                   input logic [ket_pkg::VALUE_W-1:0] value);
         table_response_type rsp;
         int                 pos;
         rsp.status      = ket_pkg::STATUS_OK;
         rsp.found_key   = '0;
         rsp.found_value = '0;
         case (op)
            ket_pkg::OP_ADD: begin
               if (entries + 1 > capacity_limit || entries >= ket_pkg::DEPTH) begin
                  rsp.status = ket_pkg::STATUS_FULL;
               end else if (find_entry(k) >= 0) begin
                  rsp.status = ket_pkg::STATUS_DUP_ADD;
               end else begin
                  entry_keys[entries]   = k;
                  entry_values[entries] = value;
                  entries++;
               end
            end
            ket_pkg::OP_DELETE: begin
               pos = find_entry(k);
               if (pos < 0) begin
                  rsp.status = ket_pkg::STATUS_DEL_MISS;
               end else begin
                  for (int i = pos; i + 1 < entries; i++) begin
                     entry_keys[i]   = entry_keys[i+1];
                     entry_values[i] = entry_values[i+1];
                  end
                  entries--;
               end
            end
            ket_pkg::OP_UPDATE: begin
               // The clash check comes before the search for the old key.
               if (nk != k && find_entry(nk) >= 0) begin
                  rsp.status = ket_pkg::STATUS_UPD_CLASH;
               end else begin
                  pos = find_entry(k);
                  if (pos < 0) begin
                     rsp.status = ket_pkg::STATUS_UPD_MISS;
                  end else begin
                     entry_keys[pos]   = nk;
                     entry_values[pos] = value;
                  end
               end
            end
            default: begin
               pos = find_entry(k);
               if (pos < 0) begin
                  rsp.status = ket_pkg::STATUS_GET_MISS;
               end else begin
                  rsp.found_key   = entry_keys[pos];
                  rsp.found_value = entry_values[pos];
               end
            end
         endcase
         rsp.entry_count = entries[ket_pkg::CNT_W-1:0];
         expected_responses.push_back(rsp);
      endfunction

      // Compares one accepted response with the oldest expectation.
      task check_response(input logic [2:0] status,
                          input logic signed [ket_pkg::KEY_W-1:0] fkey,
                          input logic [ket_pkg::VALUE_W-1:0] fvalue,
                          input logic [ket_pkg::CNT_W-1:0] count);
         table_response_type exp;
         if (expected_responses.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            exp = expected_responses.pop_front();
            if (status !== exp.status)
               report_mismatch($sformatf("status %0d, expected %0d", status, exp.status));
            if (fkey !== exp.found_key)
               report_mismatch($sformatf("found_key %0d, expected %0d", fkey,
                                         exp.found_key));
            if (fvalue !== exp.found_value)
               report_mismatch($sformatf("found_value %h, expected %h", fvalue,
                                         exp.found_value));
            if (count !== exp.entry_count)
               report_mismatch($sformatf("entry_count %0d, expected %0d", count,
                                         exp.entry_count));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   src_idle_pct;
   int   sink_idle_pct;

   ket_req_if req_bus ();
   ket_rsp_if rsp_bus ();
   ket_csr_if csr_bus ();

   table_scoreboard_type board = new();

   keyed_entry_table u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // Clock with a 4 ns period.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Response side: ready drops at random while sink idling is enabled.
   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(99) >= sink_idle_pct);
   end

   // Every accepted response is checked at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         board.check_response(rsp_bus.status, rsp_bus.found_key, rsp_bus.found_value,
                              rsp_bus.entry_count);
      end
   end

   // Sends one request transaction, with random idle cycles in front of it.
   task send_request(input ket_pkg::op_type op,
                     input logic signed [ket_pkg::KEY_W-1:0] k,
                     input logic signed [ket_pkg::KEY_W-1:0] nk,
                     input logic [ket_pkg::VALUE_W-1:0] value);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.op          = op;
      req_bus.key         = k;
      req_bus.new_key     = nk;
      req_bus.entry_value = value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.record_request(op, k, nk, value);
      @(negedge clock);
   endtask

   // Waits until every response has arrived, then lets the pipeline drain.
   task wait_for_idle();
      req_bus.valid = 1'b0;
      while (board.expected_responses.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes the capacity register; called only while the table is idle.
   task write_capacity(input logic [ket_pkg::CNT_W-1:0] value);
      wait_for_idle();
      csr_bus.valid    = 1'b1;
      csr_bus.capacity = value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      board.set_capacity(value);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Keys mostly come from a small pool so that lookups hit, with the
   // extremes and fully random keys mixed in.
   function automatic logic signed [ket_pkg::KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 32'sh8000_0000;
      if (r < 10) return 32'sh7fff_ffff;
      if (r < 15) return -32'sd1;
      if (r < 22) return $urandom;
      return $signed($urandom_range(79)) - 40;
   endfunction

   function automatic logic [ket_pkg::VALUE_W-1:0] pick_value();
      return {$urandom, $urandom};
   endfunction

   // One phase of random traffic; add_pct sets how fast the table fills.
   task run_random_phase(input int count, input int add_pct);
      ket_pkg::op_type                  op;
      logic signed [ket_pkg::KEY_W-1:0] k;
      logic signed [ket_pkg::KEY_W-1:0] nk;
      int                               r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < add_pct) op = ket_pkg::OP_ADD;
         else if (r < add_pct + (100 - add_pct) / 3) op = ket_pkg::OP_DELETE;
         else if (r < add_pct + 2 * (100 - add_pct) / 3) op = ket_pkg::OP_UPDATE;
         else op = ket_pkg::OP_GET;
         k  = pick_key();
         nk = ($urandom_range(99) < 30) ? k : pick_key();
         send_request(op, k, nk, pick_value());
      end
   endtask

   // Main sequence: reset, directed corner cases, then random phases.
   initial begin
      int phase_items;
      reset               = 1'b1;
      src_idle_pct        = 10;
      sink_idle_pct       = 10;
      req_bus.valid       = 1'b0;
      req_bus.op          = ket_pkg::OP_ADD;
      req_bus.key         = '0;
      req_bus.new_key     = '0;
      req_bus.entry_value = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.capacity    = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at a small capacity so that full is reached quickly.
      write_capacity(7'd4);
      send_request(ket_pkg::OP_GET, 32'sd0, 32'sd0, '0);
      send_request(ket_pkg::OP_DELETE, 32'sd5, 32'sd0, '0);
      send_request(ket_pkg::OP_UPDATE, 32'sd5, 32'sd5, '1);
      send_request(ket_pkg::OP_ADD, 32'sh8000_0000, 32'sd0, '0);
      send_request(ket_pkg::OP_ADD, 32'sh7fff_ffff, 32'sd0, '1);
      send_request(ket_pkg::OP_ADD, -32'sd1, 32'sd0, 64'h0123_4567_89ab_cdef);
      send_request(ket_pkg::OP_ADD, 32'sh7fff_ffff, 32'sd0, 64'h1);
      send_request(ket_pkg::OP_ADD, 32'sd0, 32'sd0, pick_value());
      send_request(ket_pkg::OP_ADD, 32'sd7, 32'sd0, pick_value());
      // A clash is reported even when the old key is absent.
      send_request(ket_pkg::OP_UPDATE, 32'sd100, -32'sd1, pick_value());
      send_request(ket_pkg::OP_UPDATE, -32'sd1, -32'sd1, 64'hfedc_ba98_7654_3210);
      send_request(ket_pkg::OP_UPDATE, 32'sd0, 32'sh5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      send_request(ket_pkg::OP_GET, 32'sh5555_5555, 32'sd0, '0);
      send_request(ket_pkg::OP_GET, 32'sh8000_0000, 32'sd0, '0);
      // Deleting from the middle shifts the later entries down.
      send_request(ket_pkg::OP_DELETE, 32'sh7fff_ffff, 32'sd0, '0);
      send_request(ket_pkg::OP_GET, -32'sd1, 32'sd0, '0);
      send_request(ket_pkg::OP_GET, 32'sh5555_5555, 32'sd0, '0);
      send_request(ket_pkg::OP_UPDATE, -32'sd1, 32'sh8000_0000, pick_value());
      send_request(ket_pkg::OP_DELETE, 32'sd12345, 32'sd0, '0);
      // Capacity below the count, then zero, then saturated to the depth.
      write_capacity(7'd1);
      send_request(ket_pkg::OP_ADD, 32'sd9, 32'sd0, pick_value());
      write_capacity(7'd0);
      send_request(ket_pkg::OP_ADD, 32'sd9, 32'sd0, pick_value());
      write_capacity(7'd127);
      send_request(ket_pkg::OP_ADD, 32'sd9, 32'sd0, pick_value());
      send_request(ket_pkg::OP_GET, 32'sd9, 32'sd0, '0);

      // Random phases at several capacities.
      phase_items = ITEMS_PER_RUN / 8;
      write_capacity(7'd64);
      run_random_phase(phase_items, 70);
      write_capacity(7'd5);
      run_random_phase(phase_items, 40);
      write_capacity(7'd0);
      run_random_phase(phase_items / 2, 40);
      write_capacity(7'd127);
      run_random_phase(phase_items, 60);
      write_capacity(7'd1);
      run_random_phase(phase_items / 2, 40);
      write_capacity(7'd40);
      run_random_phase(phase_items, 45);
      // A long stretch with no idling on either side.
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      write_capacity(7'd64);
      run_random_phase(phase_items, 50);
      src_idle_pct  = 10;
      sink_idle_pct = 10;
      write_capacity(7'($urandom_range(127)));
      run_random_phase(phase_items, 40);
      write_capacity(7'd64);
      run_random_phase(phase_items, 35);

      wait_for_idle();
      repeat (10) @(negedge clock);
      if (board.errors == 0 && board.expected_responses.size() == 0) begin
         $display("[keyed_entry_table] OK");
      end else begin
         $display("[keyed_entry_table] ERROR");
      end
      $finish;
   end

   // Overall time limit.
   initial begin
      #2ms;
      $display("[keyed_entry_table] ERROR");
      $finish;
   end

endmodule

>>> sim.f
sv/ket_pkg.sv
sv/ket_if.sv
sv/ket_cell.sv
sv/keyed_entry_table.sv
verif/tb_top.sv
